// ----- design/rtv_pkg.sv -----
// Shared types, constants and a helper function for the vertex rotate-translate pipeline.
`default_nettype none

package rtv_pkg;

    // Field widths of the coordinate and angle formats.
    localparam int COORD_W = 24;
    localparam int ANGLE_W = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_INDEX_W = 2;

    // Default number of rotation cells and the size of the arctangent table.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES = 24;

    // Rotator datapath width: Q1.30 sine/cosine and a 2^32-per-turn angle.
    localparam int ROT_W = 32;
    localparam logic signed [ROT_W-1:0] GAIN_Q30 = 32'sd652032874;

    // Widths through the multiply, round and translate stages.
    localparam int PROD_W = COORD_W + ROT_W;
    localparam int SUM_W = PROD_W + 2;
    localparam int FRAC_SHIFT = 30;
    localparam int SHIFT_W = SUM_W - FRAC_SHIFT;
    localparam int WIDE_W = SHIFT_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADING = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y = 2'd2;

    // Quadrant codes from the angle reduction.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // atan(2^-i) in 2^32-per-turn units, truncated.
    localparam logic [ROT_W-1:0] ATAN_TAB [0:MAX_STAGES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // One input beat: a vertex in the object frame.
    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } t_vertex;

    // One output beat: the vertex in the world frame.
    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic                      last_out;
    } t_result;

    // Data handed from one rotation cell to the next.
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic [1:0]              quad;
        t_vertex                 vtx;
    } t_rot_beat;

    // Clamp a widened sum to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [COORD_W-1:0] res;
        hi = WIDE_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            res = hi[COORD_W-1:0];
        end else if (v < lo) begin
            res = lo[COORD_W-1:0];
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/rtv_cordic_cell.sv -----
// One rotation-mode CORDIC cell with its own elastic register.
`default_nettype none

module rtv_cordic_cell #(
    parameter int STAGE_IDX = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  rtv_pkg::t_rot_beat  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output rtv_pkg::t_rot_beat  o_data,
    input  wire                 i_stall
);

    logic               r_valid;
    rtv_pkg::t_rot_beat r_data;
    rtv_pkg::t_rot_beat n_data;
    logic signed [rtv_pkg::ROT_W-1:0] w_dx;
    logic signed [rtv_pkg::ROT_W-1:0] w_dy;
    logic               w_load;

    // The cell holds its beat only while it is full and the next cell stalls.
    assign o_stall = r_valid && i_stall;
    assign w_load  = i_valid && !o_stall;

    // One micro-rotation: the sign of the residual angle picks the direction.
    always_comb begin
        w_dx   = $signed(i_data.y) >>> STAGE_IDX;
        w_dy   = $signed(i_data.x) >>> STAGE_IDX;
        n_data = i_data;
        if (!i_data.z[rtv_pkg::ROT_W-1]) begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - $signed(rtv_pkg::ATAN_TAB[STAGE_IDX]);
        end else begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + $signed(rtv_pkg::ATAN_TAB[STAGE_IDX]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- design/rtv_apply.sv -----
// Applies the rotation to the vertex: quadrant fix-up, products, rounding, translation.
`default_nettype none

module rtv_apply (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    input  rtv_pkg::t_rot_beat                  i_data,
    output logic                                o_stall,
    input  wire signed [rtv_pkg::COORD_W-1:0]   i_center_x,
    input  wire signed [rtv_pkg::COORD_W-1:0]   i_center_y,
    output logic                                o_valid,
    output rtv_pkg::t_result                    o_data,
    input  wire                                 i_stall
);

    localparam logic signed [rtv_pkg::SUM_W-1:0] ROUND_BIAS =
        rtv_pkg::SUM_W'(64'd1 << (rtv_pkg::FRAC_SHIFT - 1));

    // Product stage registers.
    logic                              r_a_valid;
    logic signed [rtv_pkg::PROD_W-1:0] r_a_xc;
    logic signed [rtv_pkg::PROD_W-1:0] r_a_ys;
    logic signed [rtv_pkg::PROD_W-1:0] r_a_xs;
    logic signed [rtv_pkg::PROD_W-1:0] r_a_yc;
    logic                              r_a_last;

    // Rounding stage registers.
    logic                               r_b_valid;
    logic signed [rtv_pkg::SHIFT_W-1:0] r_b_x;
    logic signed [rtv_pkg::SHIFT_W-1:0] r_b_y;
    logic                               r_b_last;

    // Output register.
    logic             r_c_valid;
    rtv_pkg::t_result r_c_data;

    logic signed [rtv_pkg::ROT_W-1:0]   w_cos;
    logic signed [rtv_pkg::ROT_W-1:0]   w_sin;
    logic signed [rtv_pkg::SUM_W-1:0]   w_sum_x;
    logic signed [rtv_pkg::SUM_W-1:0]   w_sum_y;
    logic signed [rtv_pkg::WIDE_W-1:0]  w_wx;
    logic signed [rtv_pkg::WIDE_W-1:0]  w_wy;
    logic w_a_stall;
    logic w_b_stall;
    logic w_c_stall;

    // Elastic stall chain from the output back to the input.
    assign w_c_stall = r_c_valid && i_stall;
    assign w_b_stall = r_b_valid && w_c_stall;
    assign w_a_stall = r_a_valid && w_b_stall;
    assign o_stall   = w_a_stall;

    // Map the result for the residual angle back to the full circle.
    always_comb begin
        case (i_data.quad)
            rtv_pkg::QUAD_1: begin
                w_cos = -i_data.y;
                w_sin = i_data.x;
            end
            rtv_pkg::QUAD_2: begin
                w_cos = -i_data.x;
                w_sin = -i_data.y;
            end
            rtv_pkg::QUAD_3: begin
                w_cos = i_data.y;
                w_sin = -i_data.x;
            end
            default: begin
                w_cos = i_data.x;
                w_sin = i_data.y;
            end
        endcase
    end

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!w_a_stall) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !w_a_stall) begin
            r_a_xc   <= i_data.vtx.vertex_x * w_cos;
            r_a_ys   <= i_data.vtx.vertex_y * w_sin;
            r_a_xs   <= i_data.vtx.vertex_x * w_sin;
            r_a_yc   <= i_data.vtx.vertex_y * w_cos;
            r_a_last <= i_data.vtx.last_vertex;
        end
    end

    // Sum the products and round from Q1.30 scaling back to Q15.8.
    assign w_sum_x = rtv_pkg::SUM_W'(r_a_xc) - rtv_pkg::SUM_W'(r_a_ys) + ROUND_BIAS;
    assign w_sum_y = rtv_pkg::SUM_W'(r_a_xs) + rtv_pkg::SUM_W'(r_a_yc) + ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!w_b_stall) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && !w_b_stall) begin
            r_b_x    <= w_sum_x[rtv_pkg::SUM_W-1:rtv_pkg::FRAC_SHIFT];
            r_b_y    <= w_sum_y[rtv_pkg::SUM_W-1:rtv_pkg::FRAC_SHIFT];
            r_b_last <= r_a_last;
        end
    end

    // Translate by the center and clamp to the coordinate range.
    assign w_wx = rtv_pkg::WIDE_W'(r_b_x) + rtv_pkg::WIDE_W'(i_center_x);
    assign w_wy = rtv_pkg::WIDE_W'(r_b_y) + rtv_pkg::WIDE_W'(i_center_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (!w_c_stall) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && !w_c_stall) begin
            r_c_data.world_x  <= rtv_pkg::sat_coord(w_wx);
            r_c_data.world_y  <= rtv_pkg::sat_coord(w_wy);
            r_c_data.last_out <= r_b_last;
        end
    end

    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

endmodule

`default_nettype wire

// ----- design/rotate_translate_vertex.sv -----
// Top level: configuration registers, angle reduction, CORDIC cell chain and output stages.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_stall     i_in_data  (t_vertex)
//  out      output     o_out_valid / i_out_stall   o_out_data (t_result)
//  cfg      input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// One vertex beat is accepted per clock while o_in_stall is low; each yields one
// result beat. The pipeline holds one register per rotation cell, then the product,
// rounding and translate/saturate registers.
// Every stage is an elastic register, so a stall on the output fills the
// pipeline before the input stalls. Reset clears all valid bits and the
// configuration registers.
`default_nettype none

module rotate_translate_vertex #(
    parameter int CORDIC_STAGES = rtv_pkg::CORDIC_STAGES_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  rtv_pkg::t_vertex                     i_in_data,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    output rtv_pkg::t_result                     o_out_data,
    input  wire                                  i_out_stall,
    input  wire                                  i_cfg_we,
    input  wire [rtv_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire [rtv_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam logic [rtv_pkg::ANGLE_W-1:0] QUARTER =
        rtv_pkg::ANGLE_W'(1) << (rtv_pkg::ANGLE_W - 2);

    logic [rtv_pkg::ANGLE_W-1:0]        r_heading;
    logic signed [rtv_pkg::COORD_W-1:0] r_center_x;
    logic signed [rtv_pkg::COORD_W-1:0] r_center_y;

    logic [rtv_pkg::ANGLE_W-1:0] w_turn;
    logic [1:0]                  w_quad;
    logic [rtv_pkg::ANGLE_W-1:0] w_resid;

    rtv_pkg::t_rot_beat w_beat  [CORDIC_STAGES+1];
    logic               w_valid [CORDIC_STAGES+1];
    logic               w_stall [CORDIC_STAGES+1];

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading  <= '0;
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtv_pkg::CFG_HEADING:  r_heading  <= i_cfg_data[rtv_pkg::ANGLE_W-1:0];
                rtv_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data[rtv_pkg::COORD_W-1:0];
                rtv_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data[rtv_pkg::COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Quadrant from the top bits of angle plus a quarter turn; the residual
    // is what the cells rotate through, scaled to 2^32 units per turn.
    assign w_turn  = r_heading + QUARTER;
    assign w_quad  = w_turn[rtv_pkg::ANGLE_W-1 -: 2];
    assign w_resid = r_heading - {w_quad, {(rtv_pkg::ANGLE_W-2){1'b0}}};

    assign w_beat[0].x    = rtv_pkg::GAIN_Q30;
    assign w_beat[0].y    = '0;
    assign w_beat[0].z    = {w_resid, {(rtv_pkg::ROT_W-rtv_pkg::ANGLE_W){1'b0}}};
    assign w_beat[0].quad = w_quad;
    assign w_beat[0].vtx  = i_in_data;
    assign w_valid[0] = i_in_valid;
    assign o_in_stall = w_stall[0];

    // Row of rotation cells, one shift and arctangent each.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        rtv_cordic_cell #(
            .STAGE_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_beat[g]),
            .o_stall (w_stall[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_beat[g+1]),
            .i_stall (w_stall[g+1])
        );
    end

    // Products, rounding, translation and saturation.
    rtv_apply u_apply (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[CORDIC_STAGES]),
        .i_data     (w_beat[CORDIC_STAGES]),
        .o_stall    (w_stall[CORDIC_STAGES]),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .i_stall    (i_out_stall)
    );

endmodule

`default_nettype wire
